// ===== rtl/cgs_pkg.sv =====
// ----------------------------------------------------------------------------
// cgs_pkg: shared types and constants for the color gradient span block
// Widths, limits and the request/response structs of the step divider.
// ----------------------------------------------------------------------------
package cgs_pkg;

    localparam int MAX_SPAN      = 64;
    localparam int MAX_ROW_WIDTH = 4096;

    localparam int CHAN_BITS = 8;
    localparam int FRAC_BITS = 16;
    localparam int NUM_LANES = 4;
    localparam int LANE_W    = $clog2(NUM_LANES);

    localparam int X_W     = 12;
    localparam int Y_W     = 12;
    localparam int COLOR_W = 32;
    localparam int LEN_W   = 7;
    localparam int ROW_W   = 13;
    localparam int IDX_W   = 25;

    localparam int CNT_W     = $clog2(MAX_SPAN + 1);
    localparam int DIVISOR_W = $clog2(MAX_SPAN);
    localparam int DIV_BITS  = CHAN_BITS + FRAC_BITS;   // 8.16 quotient
    localparam int DIV_CNT_W = $clog2(DIV_BITS);
    localparam int ACC_W     = DIV_BITS + 1;            // signed step / accumulator

    localparam logic [ROW_W-1:0] ROW_WIDTH_RST = ROW_W'(640);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ROW_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 1'b1;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 64;

    typedef struct packed {
        logic                 start;
        logic [DIV_BITS-1:0]  dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/cgs_div.sv =====
// ----------------------------------------------------------------------------
// cgs_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses when the final quotient is registered.
// ----------------------------------------------------------------------------
module cgs_div
    import cgs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIV_BITS-1:0]  quo_reg;

    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (req.start) begin
                busy_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (fits) begin
                rem_reg <= DIVISOR_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_reg <= trial[DIVISOR_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_BITS-2:0], fits};
        end else if (req.start) begin
            cnt_reg <= DIV_CNT_W'(DIV_BITS - 1);
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            quo_reg <= req.dividend;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/color_gradient_span.sv =====
// ----------------------------------------------------------------------------
// color_gradient_span: linear color gradient along one horizontal span
// Sequencer around a shared serial divider plus a per-pixel color stepper.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one span transaction (start pixel, row, two colors, length);
//   m_* returns one transaction per pixel with its linear index, color and
//   tlast on the final pixel. A length of zero yields no output.
//   cfg_* writes row_width (index 0) and channel_mode (index 1); it is always
//   ready and is meant to be used only while the block is idle.
// Timing:
//   s_tready is high only while idle. After acceptance a setup state forms the
//   row base index, then each color channel (3 or 4) runs through the single
//   restoring divider, one quotient bit per cycle; a one pixel span skips the
//   divider and goes straight to output. Pixels then leave at one per cycle
//   while m_tready is high.
// Reset / stall:
//   aresetn (sync, active low) returns to idle, drops m_tvalid and sets
//   row_width 640, channel_mode 0. When m_tready is low the output register
//   holds its transaction and the stepper waits; the last pixel may still sit
//   in the output register while the next span is accepted.
// ----------------------------------------------------------------------------
module color_gradient_span
    import cgs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: start_x[11:0], start_y[23:12], start_color[55:24],
    //          end_color[87:56], span_length[94:88], zero pad[95]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // m_tdata: pixel_index[24:0], pixel_color[56:25], zero pad[63:57]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,     // last_pixel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SETUP    = 5'b00010,
        ST_DIV_GO   = 5'b00100,
        ST_DIV_WAIT = 5'b01000,
        ST_EMIT     = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [ROW_W-1:0] row_width_reg;
    logic             mode_reg;

    // span captured at acceptance
    logic [X_W-1:0]     x_reg;
    logic [Y_W-1:0]     y_reg;
    logic [COLOR_W-1:0] c0_reg;
    logic [COLOR_W-1:0] c1_reg;
    logic [CNT_W-1:0]   n_reg;

    // stepper
    logic [ACC_W-1:0]  acc_reg  [NUM_LANES];
    logic [ACC_W-1:0]  step_reg [NUM_LANES];
    logic [LANE_W-1:0] lane_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  idx_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                 s_fire;
    logic [X_W-1:0]       in_x;
    logic [Y_W-1:0]       in_y;
    logic [COLOR_W-1:0]   in_c0, in_c1;
    logic [LEN_W-1:0]     in_len;
    logic [COLOR_W-1:0]   color_mask;
    logic [ROW_W-1:0]     rw_sat;
    logic [CHAN_BITS-1:0] lane_a, lane_b;
    logic                 lane_neg;
    logic [CHAN_BITS-1:0] lane_mag;
    logic [LANE_W-1:0]    last_lane;
    logic                 out_load;
    logic [COLOR_W-1:0]   pix_color;

    assign in_x   = s_tdata[11:0];
    assign in_y   = s_tdata[23:12];
    assign in_c0  = s_tdata[55:24];
    assign in_c1  = s_tdata[87:56];
    assign in_len = s_tdata[94:88];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    // RGB mode drops the top byte of both colors
    assign color_mask = mode_reg ? '1 : {{CHAN_BITS{1'b0}}, {(COLOR_W - CHAN_BITS){1'b1}}};
    assign rw_sat     = (row_width_reg > ROW_W'(MAX_ROW_WIDTH)) ?
                        ROW_W'(MAX_ROW_WIDTH) : row_width_reg;
    assign last_lane  = mode_reg ? LANE_W'(NUM_LANES - 1) : LANE_W'(NUM_LANES - 2);

    assign lane_a   = c0_reg[lane_reg*CHAN_BITS +: CHAN_BITS];
    assign lane_b   = c1_reg[lane_reg*CHAN_BITS +: CHAN_BITS];
    assign lane_neg = lane_b < lane_a;
    assign lane_mag = lane_neg ? CHAN_BITS'(lane_a - lane_b) : CHAN_BITS'(lane_b - lane_a);

    assign div_req.start    = (state_reg == ST_DIV_GO);
    assign div_req.dividend = {lane_mag, {FRAC_BITS{1'b0}}};
    assign div_req.divisor  = DIVISOR_W'(n_reg - 1'b1);

    cgs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // integer part of each lane accumulator
    always_comb begin
        for (int j = 0; j < NUM_LANES; j++) begin
            pix_color[j*CHAN_BITS +: CHAN_BITS] = acc_reg[j][FRAC_BITS +: CHAN_BITS];
        end
    end

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && in_len != '0) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = (n_reg == CNT_W'(1)) ? ST_EMIT : ST_DIV_GO;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (lane_reg == last_lane) ? ST_EMIT : ST_DIV_GO;
                end
            end
            ST_EMIT: begin
                if (out_load && cnt_reg == CNT_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            row_width_reg <= ROW_WIDTH_RST;
            mode_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROW_WIDTH:    row_width_reg <= cfg_data;
                    CFG_CHANNEL_MODE: mode_reg      <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_reg  <= in_x;
            y_reg  <= in_y;
            c0_reg <= in_c0 & color_mask;
            c1_reg <= in_c1 & color_mask;
            n_reg  <= (in_len > LEN_W'(MAX_SPAN)) ? CNT_W'(MAX_SPAN) : CNT_W'(in_len);
        end

        case (state_reg)
            ST_SETUP: begin
                idx_reg  <= IDX_W'(rw_sat) * IDX_W'(y_reg) + IDX_W'(x_reg);
                cnt_reg  <= n_reg;
                lane_reg <= '0;
                for (int j = 0; j < NUM_LANES; j++) begin
                    acc_reg[j]  <= {1'b0, c0_reg[j*CHAN_BITS +: CHAN_BITS],
                                    {FRAC_BITS{1'b0}}};
                    step_reg[j] <= '0;
                end
            end
            ST_DIV_GO: begin
                neg_reg <= lane_neg;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    step_reg[lane_reg] <= neg_reg ? ACC_W'(-{1'b0, div_rsp.quotient})
                                                  : {1'b0, div_rsp.quotient};
                    lane_reg <= lane_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    idx_reg <= idx_reg + 1'b1;
                    cnt_reg <= cnt_reg - 1'b1;
                    for (int j = 0; j < NUM_LANES; j++) begin
                        acc_reg[j] <= acc_reg[j] + step_reg[j];
                    end
                end
            end
            default: ;
        endcase

        if (out_load) begin
            out_idx_reg   <= idx_reg;
            out_color_reg <= pix_color;
            out_last_reg  <= (cnt_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_W - COLOR_W){1'b0}}, out_color_reg, out_idx_reg};

`ifndef NO_ASSERTIONS
    a_div_busy_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> state_reg == ST_DIV_WAIT)
        else $error("divider busy outside wait state");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider done outside wait state");

    a_busy_after_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_len != '0) |=> !s_tready)
        else $error("input ready while a span is in work");

    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> cnt_reg != '0)
        else $error("emitting with no pixels left");
`endif

endmodule
